// ===== rtl/core/sorted_key_table_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the sorted key table
// Shared forms for the concurrent checks on the table's stream ports.
// ---------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_CORE_MACROS_SVH
`define SORTED_KEY_TABLE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SKT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SKT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/skt_pkg.sv =====
// ---------------------------------------------------------------------------
// Sorted key table package
// Record type, cell command type and the codes shared by the table's modules.
// ---------------------------------------------------------------------------
package skt_pkg;

    localparam int KEY_W   = 32;
    localparam int AGE_W   = 8;
    localparam int SCORE_W = 16;
    localparam int STAT_W  = 3;
    localparam int KIND_W  = 2;
    localparam int OP_W    = 2;

    // Padding that fills the result transaction's data to whole bytes.
    localparam int OUT_FIELDS_W = STAT_W + KEY_W + AGE_W + SCORE_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;
    localparam int IN_DATA_W    = KEY_W + AGE_W + SCORE_W;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DUMP   = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_INSERTED = 3'd0;
    localparam logic [STAT_W-1:0] STAT_DELETED  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_DUP      = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd3;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd4;
    localparam logic [STAT_W-1:0] STAT_FULL     = 3'd5;
    localparam logic [STAT_W-1:0] STAT_LISTED   = 3'd6;

    // Cell operations.
    localparam logic [OP_W-1:0] OP_HOLD   = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
    localparam logic [OP_W-1:0] OP_ROTATE = 2'd3;

    typedef struct packed {
        logic                     valid;
        logic signed [KEY_W-1:0]  key;
        logic [AGE_W-1:0]         age;
        logic [SCORE_W-1:0]       score;
    } rec_t;

    // Broadcast from the control logic to every cell.
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic                     cmp_en;
        logic signed [KEY_W-1:0]  key;
        logic [AGE_W-1:0]         age;
        logic [SCORE_W-1:0]       score;
    } cell_cmd_t;

endpackage

// ===== rtl/core/sorted_key_table_core.sv =====
// ---------------------------------------------------------------------------
// Sorted key table core
// A bounded table of records kept in ascending signed key order.
// ---------------------------------------------------------------------------
// Requests arrive on the s_axis channel: tuser carries the kind (insert,
// delete or dump) and tdata carries key, age and score. Results leave on the
// m_axis channel with tlast on the final result of each request.
// The table is a row of CAPACITY cells. A request transaction is accepted
// only while the control is idle; in that same cycle every cell compares its
// key with the request key. Once the output register is free, the EXEC state
// decides insert or delete from the registered compare flags, shifts the
// cells and loads the single result into the output register.
// A dump passes from EXEC to the DUMP state, which, each time the output
// register is free, sends the record in cell 0 to the output while the valid
// records rotate by one slot, so the table is back in order after the last
// record. An empty table answers with a single list-empty result. Kind three
// produces no result.
// The output register holds a result until the receiver takes it; while the
// receiver stalls, the next request can still be accepted and compared, but
// the following step waits for the output register to drain.
// Reset clears the cell valid bits and the record count, leaving the table
// empty; the block is ready as soon as reset is released.
// ---------------------------------------------------------------------------
module sorted_key_table_core #(
    parameter int CAPACITY = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Request: tdata = key[31:0], age[39:32], score[55:40]
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [skt_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // Request: tuser = kind[1:0]
    input  logic [skt_pkg::KIND_W-1:0]        s_axis_tuser,
    // Result: tdata = status[2:0], entry_key[34:3], entry_age[42:35],
    // entry_score[58:43], zero padding above
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [skt_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tlast
);
    import skt_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_DUMP = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           remain_reg, remain_next;

    // Held request fields.
    logic [KIND_W-1:0]       req_kind_reg;
    logic signed [KEY_W-1:0] req_key_reg;
    logic [AGE_W-1:0]        req_age_reg;
    logic [SCORE_W-1:0]      req_score_reg;

    // Output register.
    logic                    out_valid_reg;
    logic [STAT_W-1:0]       out_status_reg;
    logic signed [KEY_W-1:0] out_key_reg;
    logic [AGE_W-1:0]        out_age_reg;
    logic [SCORE_W-1:0]      out_score_reg;
    logic                    out_last_reg;

    logic                    load;
    logic [STAT_W-1:0]       ld_status;
    logic signed [KEY_W-1:0] ld_key;
    logic [AGE_W-1:0]        ld_age;
    logic [SCORE_W-1:0]      ld_score;
    logic                    ld_last;

    logic                    accept;
    logic                    out_free;
    logic [OP_W-1:0]         cell_op;
    cell_cmd_t               cmd;
    rec_t                    cell_rec [CAPACITY];
    logic [CAPACITY-1:0]     cell_lt;
    logic [CAPACITY-1:0]     cell_eq;
    logic                    any_eq;
    logic                    full;
    logic                    empty;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign any_eq = |cell_eq;
    assign full   = cell_rec[CAPACITY-1].valid;
    assign empty  = !cell_rec[0].valid;

    // The compare runs on the incoming key in the accept cycle; later steps
    // use the held request.
    always_comb
    begin
        cmd.op     = cell_op;
        cmd.cmp_en = accept;
        cmd.key    = accept ? $signed(s_axis_tdata[KEY_W-1:0]) : req_key_reg;
        cmd.age    = req_age_reg;
        cmd.score  = req_score_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            rec_t left_rec;
            rec_t right_rec;
            logic left_lt;

            if (gi == 0)
            begin : g_first
                assign left_rec = '0;
                assign left_lt  = 1'b1;
            end
            else
            begin : g_mid
                assign left_rec = cell_rec[gi-1];
                assign left_lt  = cell_lt[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_rec = '0;
            end
            else
            begin : g_inner
                assign right_rec = cell_rec[gi+1];
            end

            skt_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .cmd     (cmd),
                .left    (left_rec),
                .left_lt (left_lt),
                .right   (right_rec),
                .head    (cell_rec[0]),
                .rec     (cell_rec[gi]),
                .lt      (cell_lt[gi]),
                .eq      (cell_eq[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        remain_next = remain_reg;
        cell_op     = OP_HOLD;
        load        = 1'b0;
        ld_status   = STAT_INSERTED;
        ld_key      = req_key_reg;
        ld_age      = '0;
        ld_score    = '0;
        ld_last     = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (req_kind_reg)
                    KIND_INSERT:
                    begin
                        if (out_free)
                        begin
                            load       = 1'b1;
                            state_next = ST_IDLE;
                            // A duplicate key wins over a full table.
                            if (any_eq)
                            begin
                                ld_status = STAT_DUP;
                            end
                            else if (full)
                            begin
                                ld_status = STAT_FULL;
                            end
                            else
                            begin
                                ld_status  = STAT_INSERTED;
                                cell_op    = OP_INSERT;
                                count_next = count_reg + CW'(1);
                            end
                        end
                    end
                    KIND_DELETE:
                    begin
                        if (out_free)
                        begin
                            load       = 1'b1;
                            state_next = ST_IDLE;
                            if (empty)
                            begin
                                ld_status = STAT_EMPTY;
                            end
                            else if (!any_eq)
                            begin
                                ld_status = STAT_NOTFOUND;
                            end
                            else
                            begin
                                ld_status  = STAT_DELETED;
                                cell_op    = OP_DELETE;
                                count_next = count_reg - CW'(1);
                            end
                        end
                    end
                    KIND_DUMP:
                    begin
                        if (empty)
                        begin
                            if (out_free)
                            begin
                                load       = 1'b1;
                                ld_status  = STAT_EMPTY;
                                state_next = ST_IDLE;
                            end
                        end
                        else
                        begin
                            remain_next = count_reg;
                            state_next  = ST_DUMP;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_DUMP:
            begin
                if (out_free)
                begin
                    load        = 1'b1;
                    ld_status   = STAT_LISTED;
                    ld_key      = cell_rec[0].key;
                    ld_age      = cell_rec[0].age;
                    ld_score    = cell_rec[0].score;
                    ld_last     = (remain_reg == CW'(1));
                    cell_op     = OP_ROTATE;
                    remain_next = remain_reg - CW'(1);
                    if (remain_reg == CW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_kind_reg  <= s_axis_tuser;
            req_key_reg   <= $signed(s_axis_tdata[KEY_W-1:0]);
            req_age_reg   <= s_axis_tdata[KEY_W +: AGE_W];
            req_score_reg <= s_axis_tdata[KEY_W+AGE_W +: SCORE_W];
        end
        if (load)
        begin
            out_status_reg <= ld_status;
            out_key_reg    <= ld_key;
            out_age_reg    <= ld_age;
            out_score_reg  <= ld_score;
            out_last_reg   <= ld_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_score_reg, out_age_reg,
                            out_key_reg, out_status_reg};

endmodule

// ===== rtl/core/skt_cell.sv =====
// ---------------------------------------------------------------------------
// Sorted key table cell
// Holds one record slot, compares it with the request key and shifts or
// rotates records with its neighbors.
// ---------------------------------------------------------------------------
module skt_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  skt_pkg::cell_cmd_t cmd,
    input  skt_pkg::rec_t      left,
    input  logic               left_lt,
    input  skt_pkg::rec_t      right,
    input  skt_pkg::rec_t      head,
    output skt_pkg::rec_t      rec,
    output logic               lt,
    output logic               eq
);
    import skt_pkg::*;

    rec_t rec_reg;
    rec_t rec_next;
    logic lt_reg;
    logic eq_reg;
    logic cmp_lt;
    logic cmp_eq;

    assign cmp_lt = rec_reg.valid && ($signed(rec_reg.key) < $signed(cmd.key));
    assign cmp_eq = rec_reg.valid && (rec_reg.key == cmd.key);

    // On insert and delete, a slot whose key is below the request key keeps its
    // record; all slots from the sorted position onward shift as one.
    always_comb
    begin
        rec_next = rec_reg;
        case (cmd.op)
            OP_INSERT:
            begin
                if (!lt_reg)
                begin
                    if (left_lt)
                    begin
                        rec_next.valid = 1'b1;
                        rec_next.key   = cmd.key;
                        rec_next.age   = cmd.age;
                        rec_next.score = cmd.score;
                    end
                    else
                    begin
                        rec_next = left;
                    end
                end
            end
            OP_DELETE:
            begin
                if (!lt_reg)
                begin
                    rec_next = right;
                end
            end
            OP_ROTATE:
            begin
                if (right.valid)
                begin
                    rec_next = right;
                end
                else if (rec_reg.valid)
                begin
                    rec_next = head;
                end
            end
            default:
            begin
                rec_next = rec_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg <= '0;
            lt_reg  <= 1'b0;
            eq_reg  <= 1'b0;
        end
        else
        begin
            rec_reg <= rec_next;
            if (cmd.cmp_en)
            begin
                lt_reg <= cmp_lt;
                eq_reg <= cmp_eq;
            end
        end
    end

    assign rec = rec_reg;
    assign lt  = lt_reg;
    assign eq  = eq_reg;

endmodule

// ===== rtl/core/sorted_key_table_core_chk.sv =====
// ---------------------------------------------------------------------------
// Sorted key table port checker
// Concurrent checks on the table's stream ports, bound to the core.
// ---------------------------------------------------------------------------
`include "sorted_key_table_core_macros.svh"

module sorted_key_table_core_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // A stalled result must stay offered.
    `SKT_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")

    // After a request is taken, the next request waits for the decision step.
    `SKT_ASSERT_NEXT(a_one_request, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while busy")

    // Status codes stay within the defined set.
    `SKT_ASSERT_SAME(a_status_range, clk, rst_n, m_axis_tvalid, m_axis_tdata[2:0] != 3'd7, "undefined status")

    // Only listed entries carry age and score, and every other result ends its request.
    `SKT_ASSERT_SAME(a_plain_result, clk, rst_n, m_axis_tvalid && (m_axis_tdata[2:0] != 3'd6), m_axis_tlast && (m_axis_tdata[58:35] == 24'd0), "bad non-list result")

endmodule

bind sorted_key_table_core sorted_key_table_core_chk u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
